/* rtl/text_byte_normalizer_assert.svh */
// Assertion macros for the text byte normalizer.
// Included by the top level; the macros expand to nothing under SYNTHESIS.
`ifndef TEXT_BYTE_NORMALIZER_ASSERT_SVH
`define TEXT_BYTE_NORMALIZER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every clock edge outside reset.
`define TBN_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("text_byte_normalizer: check failed");
// Next-cycle implication.
`define TBN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("text_byte_normalizer: check failed");
`else
`define TBN_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TBN_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/tbn_pkg.sv */
// Types, byte codes and the per-item normalizing step of the text byte normalizer.
// No dependencies; used by the front, queue, back and top modules.
package tbn_pkg;

	localparam int MAX_CHARS = 4;

	localparam logic [7:0] BYTE_TAB   = 8'h09;
	localparam logic [7:0] BYTE_LF    = 8'h0A;
	localparam logic [7:0] BYTE_CR    = 8'h0D;
	localparam logic [7:0] BYTE_SP    = 8'h20;
	localparam logic [7:0] BYTE_DEL   = 8'h7F;
	localparam logic [7:0] BYTE_E2    = 8'hE2;
	localparam logic [7:0] BYTE_80    = 8'h80;
	localparam logic [7:0] BYTE_C2    = 8'hC2;
	localparam logic [7:0] BYTE_A0    = 8'hA0;
	localparam logic [7:0] BYTE_LSQ   = 8'h98;
	localparam logic [7:0] BYTE_RSQ   = 8'h99;
	localparam logic [7:0] BYTE_LDQ   = 8'h9C;
	localparam logic [7:0] BYTE_RDQ   = 8'h9D;
	localparam logic [7:0] BYTE_ENDASH = 8'h93;
	localparam logic [7:0] BYTE_EMDASH = 8'h94;
	localparam logic [7:0] BYTE_ELLIP = 8'hA6;

	localparam logic [6:0] CH_LF    = 7'h0A;
	localparam logic [6:0] CH_SPACE = 7'h20;
	localparam logic [6:0] CH_QUOTE = 7'h22;
	localparam logic [6:0] CH_APOS  = 7'h27;
	localparam logic [6:0] CH_DASH  = 7'h2D;
	localparam logic [6:0] CH_DOT   = 7'h2E;

	typedef enum logic [1:0] {
		PFX_NONE,
		PFX_E2,
		PFX_E2_80,
		PFX_C2
	} prefix_t;

	typedef struct packed {
		prefix_t    pfx;
		logic       nl;
		logic [1:0] lf;
		logic       ps;
	} norm_state_t;

	// All characters one input item produces, handed from front to back.
	typedef struct packed {
		logic [MAX_CHARS-1:0][6:0] chars;
		logic [2:0]                count;
		logic                      fin;
	} bundle_t;

	typedef struct packed {
		norm_state_t st;
		bundle_t     bnd;
	} work_t;

	function automatic work_t put_char(work_t w, logic [6:0] ch);
		work_t r;
		logic  keep;
		r = w;
		keep = 1'b1;
		if (ch == CH_SPACE) begin
			if (w.st.ps) begin
				keep = 1'b0;
			end
			r.st.ps = 1'b1;
		end else begin
			r.st.ps = 1'b0;
		end
		if (keep && (r.bnd.count < 3'(MAX_CHARS))) begin
			r.bnd.chars[r.bnd.count[1:0]] = ch;
			r.bnd.count = r.bnd.count + 3'd1;
		end
		return r;
	endfunction

	function automatic work_t flush_run(work_t w);
		work_t r;
		r = put_char(w, (w.st.lf >= 2'd2) ? CH_LF : CH_SPACE);
		r.st.nl = 1'b0;
		r.st.lf = 2'd0;
		return r;
	endfunction

	// Handling of a byte with no prefix held and no run open.
	function automatic work_t handle_fresh(work_t w, logic [7:0] b);
		work_t r;
		r = w;
		if (b == BYTE_E2) begin
			r.st.pfx = PFX_E2;
		end else if (b == BYTE_C2) begin
			r.st.pfx = PFX_C2;
		end else if (b == BYTE_LF || b == BYTE_CR) begin
			r.st.nl = 1'b1;
			r.st.lf = (b == BYTE_LF) ? 2'd1 : 2'd0;
		end else if (b >= BYTE_SP && b < BYTE_DEL) begin
			r = put_char(w, b[6:0]);
		end else if (b == BYTE_TAB) begin
			r = put_char(w, CH_SPACE);
		end
		return r;
	endfunction

	function automatic work_t norm_step(norm_state_t s, logic [7:0] b, logic fin);
		work_t w;
		w.st = s;
		w.bnd = '0;
		w.bnd.fin = fin;
		if (s.nl) begin
			if (b == BYTE_LF || b == BYTE_CR) begin
				if (b == BYTE_LF && s.lf < 2'd2) begin
					w.st.lf = s.lf + 2'd1;
				end
			end else begin
				w = flush_run(w);
				w = handle_fresh(w, b);
			end
		end else begin
			case (s.pfx)
				PFX_E2: begin
					w.st.pfx = PFX_NONE;
					if (b == BYTE_80) begin
						w.st.pfx = PFX_E2_80;
					end else begin
						w = handle_fresh(w, b);
					end
				end
				PFX_E2_80: begin
					w.st.pfx = PFX_NONE;
					case (b)
						BYTE_LSQ, BYTE_RSQ:       w = put_char(w, CH_APOS);
						BYTE_LDQ, BYTE_RDQ:       w = put_char(w, CH_QUOTE);
						BYTE_ENDASH, BYTE_EMDASH: w = put_char(w, CH_DASH);
						BYTE_ELLIP: begin
							w = put_char(w, CH_DOT);
							w = put_char(w, CH_DOT);
							w = put_char(w, CH_DOT);
						end
						default:                  w = handle_fresh(w, b);
					endcase
				end
				PFX_C2: begin
					w.st.pfx = PFX_NONE;
					if (b == BYTE_A0) begin
						w = put_char(w, CH_SPACE);
					end else begin
						w = handle_fresh(w, b);
					end
				end
				default: w = handle_fresh(w, b);
			endcase
		end
		if (fin) begin
			if (w.st.nl) begin
				w = flush_run(w);
			end
			w.st = '0;
		end
		return w;
	endfunction

endpackage

/* rtl/tbn_if.sv */
// Valid/ready channel interfaces for the text byte normalizer's input and output items.
// No dependencies.
interface tbn_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       final_byte;

	modport source (output valid, output in_byte, output final_byte, input ready);
	modport sink (input valid, input in_byte, input final_byte, output ready);
endinterface

interface tbn_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] out_byte;
	logic       has_byte;
	logic       last_of_run;
	logic       end_of_text;

	modport source (output valid, output out_byte, output has_byte, output last_of_run,
		output end_of_text, input ready);
	modport sink (input valid, input out_byte, input has_byte, input last_of_run,
		input end_of_text, output ready);
endinterface

/* rtl/tbn_front.sv */
// Front end: accepts items, runs the normalizing step and pushes non-empty or final bundles.
// Depends on tbn_pkg and tbn_in_if.
module tbn_front
	import tbn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	tbn_in_if.sink      in_ch,
	output logic        push_valid,
	output bundle_t     push_bundle,
	input  logic        push_ready,
	output norm_state_t state
);

	norm_state_t st_q;
	work_t       work;
	logic        accept;

	assign in_ch.ready = push_ready;
	assign accept      = in_ch.valid && push_ready;

	always_comb begin
		work = norm_step(st_q, in_ch.in_byte, in_ch.final_byte);
	end

	// Items that produce nothing and do not end the text leave no bundle behind.
	assign push_valid  = accept && ((work.bnd.count != 3'd0) || work.bnd.fin);
	assign push_bundle = work.bnd;
	assign state       = st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (accept) begin
			st_q <= work.st;
		end
	end

endmodule

/* rtl/tbn_queue.sv */
// Small bundle queue between the front and back ends.
// Depends on tbn_pkg.
module tbn_queue
	import tbn_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t push_bundle,
	output logic    ready,
	output logic    head_valid,
	output bundle_t head_bundle,
	input  logic    pop
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	bundle_t            mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               do_push;
	logic               do_pop;

	assign ready       = (cnt_q != CNT_W'(DEPTH));
	assign head_valid  = (cnt_q != '0);
	assign head_bundle = mem_q[rd_q];
	assign do_push     = push && ready;
	assign do_pop      = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_bundle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/tbn_back.sv */
// Back end: walks the head bundle, one char per unstalled cycle, into the output register.
// Depends on tbn_pkg and tbn_out_if.
module tbn_back
	import tbn_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  bundle_t   head_bundle,
	output logic      pop,
	tbn_out_if.source out_ch
);

	logic       ov_q;
	logic [1:0] idx_q;
	logic [6:0] byte_q;
	logic       has_q;
	logic       last_q;
	logic       eot_q;
	logic       load;
	logic       is_last;
	logic       empty_marker;

	assign empty_marker = (head_bundle.count == 3'd0);
	// An empty end marker is a single result; otherwise the last character ends the item.
	assign is_last = empty_marker || ({1'b0, idx_q} == head_bundle.count - 3'd1);
	assign load    = head_valid && (!ov_q || out_ch.ready);
	assign pop     = load && is_last;

	assign out_ch.valid       = ov_q;
	assign out_ch.out_byte    = byte_q;
	assign out_ch.has_byte    = has_q;
	assign out_ch.last_of_run = last_q;
	assign out_ch.end_of_text = eot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load) begin
				ov_q  <= 1'b1;
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (out_ch.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= empty_marker ? 7'd0 : head_bundle.chars[idx_q];
			has_q  <= !empty_marker;
			last_q <= is_last;
			eot_q  <= is_last && head_bundle.fin;
		end
	end

endmodule

/* rtl/text_byte_normalizer.sv */
// Text byte normalizer: takes raw text bytes and gives normalized ASCII bytes.
// Depends on tbn_pkg, tbn_if, tbn_front, tbn_queue, tbn_back and the assertion header.
//
// in_ch carries one raw byte per item with final_byte marking the end of the text.
// out_ch carries one result per item: an ASCII character, or on a last byte that
// produced nothing, an empty end marker with has_byte low. last_of_run flags the
// final result of each input byte, end_of_text the final result of the text.
// Both channels complete a transfer when valid and ready are high at a clock edge.
//
// The front end accepts one byte per cycle while the queue has room and works out
// all of that byte's characters in the same cycle. The back end then sends them one
// per cycle, while the receiver takes them, from a registered output stage, so the
// first result passes through the queue and then the output register before it is offered.
// A byte that yields more than one character holds the back end until all are sent;
// bytes yielding zero or one sustain one item per cycle while the receiver keeps up.
// The queue of QUEUE_DEPTH bundles lets the input keep flowing while the receiver
// stalls, until the queue fills and in_ch.ready drops.
// Reset clears the prefix, newline-run and space state and empties the queue.
`include "text_byte_normalizer_assert.svh"

module text_byte_normalizer
	import tbn_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	tbn_in_if.sink     in_ch,
	tbn_out_if.source  out_ch
);

	logic        push_valid;
	bundle_t     push_bundle;
	logic        push_ready;
	logic        head_valid;
	bundle_t     head_bundle;
	logic        pop;
	norm_state_t front_state;

	tbn_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.push_valid  (push_valid),
		.push_bundle (push_bundle),
		.push_ready  (push_ready),
		.state       (front_state)
	);

	tbn_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push_valid),
		.push_bundle (push_bundle),
		.ready       (push_ready),
		.head_valid  (head_valid),
		.head_bundle (head_bundle),
		.pop         (pop)
	);

	tbn_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_bundle (head_bundle),
		.pop         (pop),
		.out_ch      (out_ch)
	);

	`TBN_ASSERT_NEXT(a_final_clears_state, clk, arst_n, in_ch.valid && in_ch.ready && in_ch.final_byte, front_state == '0)
	`TBN_ASSERT_IMPL(a_lf_saturates, clk, arst_n, 1'b1, front_state.lf != 2'd3)
	`TBN_ASSERT_IMPL(a_marker_ends_text, clk, arst_n, out_ch.valid && !out_ch.has_byte, out_ch.end_of_text && out_ch.last_of_run && out_ch.out_byte == 7'd0)
	`TBN_ASSERT_IMPL(a_eot_is_last, clk, arst_n, out_ch.valid && out_ch.end_of_text, out_ch.last_of_run)

endmodule
